@@ rtl/core/positional_list_engine_assert.svh @@
// assertion macros shared by the positional list engine
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PLE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/ple_pkg.sv @@
// package: widths, codes and helpers of the positional list engine
package ple_pkg;

    // field widths
    localparam int CMD_W   = 2;
    localparam int POS_W   = 5;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int FIDX_W  = 4;
    localparam int CNT_W   = 5;

    // default list depth
    localparam int DEPTH_DEF = 16;

    // scan group size (hit bits examined per cycle)
    localparam int GRP_SZ  = 8;
    localparam int GRP_BW  = 3;

    // operation codes
    localparam logic [CMD_W-1:0] CMD_INS = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REM = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FND = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    // per-cell operation strobes
    typedef struct packed {
        logic ins;
        logic rem;
        logic fnd;
    } t_cell_op;

    // scan status towards the control
    typedef struct packed {
        logic done;
        logic found;
    } t_scan_st;

    // number of scan groups for a given depth
    function automatic int scan_groups(input int depth);
        return (depth + GRP_SZ - 1) >> GRP_BW;
    endfunction

    // width of the group counter
    function automatic int scan_grp_w(input int depth);
        return (scan_groups(depth) > 1) ? $clog2(scan_groups(depth)) : 1;
    endfunction

    // width of a compare operand covering both position and count
    function automatic int cmp_w(input int depth);
        return ($clog2(depth + 1) > POS_W) ? $clog2(depth + 1) : POS_W;
    endfunction

endpackage

@@ rtl/core/ple_req_if.sv @@
// request channel interface: operation, position and value
interface ple_req_if;
    logic                          valid;
    logic                          ready;
    logic [ple_pkg::CMD_W-1:0]     cmd;
    logic [ple_pkg::POS_W-1:0]     position;
    logic signed [ple_pkg::VAL_W-1:0] item_value;

    modport source (output valid, cmd, position, item_value, input ready);
    modport sink   (input valid, cmd, position, item_value, output ready);
endinterface

@@ rtl/core/ple_res_if.sv @@
// result channel interface: status, found index and entry count
interface ple_res_if;
    logic                          valid;
    logic                          ready;
    logic [ple_pkg::STAT_W-1:0]    status;
    logic [ple_pkg::FIDX_W-1:0]    found_index;
    logic [ple_pkg::CNT_W-1:0]     entry_count;

    modport source (output valid, status, found_index, entry_count, input ready);
    modport sink   (input valid, status, found_index, entry_count, output ready);
endinterface

@@ rtl/core/ple_cell.sv @@
// one list cell: holds an entry, shifts with its neighbours, compares on find
module ple_cell #(
    parameter int IDX  = 0,
    parameter int CMPW = 5
) (
    input  logic                            i_clk,
    input  ple_pkg::t_cell_op               i_op,
    input  logic [CMPW-1:0]                 i_pos,
    input  logic [CMPW-1:0]                 i_count,
    input  logic signed [ple_pkg::VAL_W-1:0] i_value,
    input  logic signed [ple_pkg::VAL_W-1:0] i_left,
    input  logic signed [ple_pkg::VAL_W-1:0] i_right,
    output logic signed [ple_pkg::VAL_W-1:0] o_entry,
    output logic                            o_hit
);

    localparam logic [CMPW-1:0] K = CMPW'(IDX);

    logic signed [ple_pkg::VAL_W-1:0] r_entry;
    logic                             r_hit;

    // entry update: insert opens a slot, remove closes one
    always_ff @(posedge i_clk) begin
        if (i_op.ins) begin
            if (K == i_pos) begin
                r_entry <= i_value;
            end else if (K > i_pos) begin
                r_entry <= i_left;
            end
        end else if (i_op.rem) begin
            if (K >= i_pos) begin
                r_entry <= i_right;
            end
        end
    end

    // match flag, only for live entries
    always_ff @(posedge i_clk) begin
        if (i_op.fnd) begin
            r_hit <= (K < i_count) && (r_entry == i_value);
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;

endmodule

@@ rtl/core/ple_scan.sv @@
// first-match search over the cell hit flags, one group of eight a cycle
module ple_scan #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_start,
    input  logic [DEPTH-1:0]                                i_hits,
    output ple_pkg::t_scan_st                               o_st,
    output logic [ple_pkg::scan_grp_w(DEPTH)+ple_pkg::GRP_BW-1:0] o_index
);

    localparam int G  = ple_pkg::scan_groups(DEPTH);
    localparam int GW = ple_pkg::scan_grp_w(DEPTH);
    localparam int MW = G * ple_pkg::GRP_SZ;

    logic [MW-1:0]                   r_vec;
    logic [GW-1:0]                   r_grp;
    logic                            r_busy;
    logic [ple_pkg::GRP_SZ-1:0]      low;
    logic [ple_pkg::GRP_BW-1:0]      enc;
    logic                            any;
    logic                            last;

    // lowest set bit of the current group
    always_comb begin
        low = r_vec[ple_pkg::GRP_SZ-1:0];
        any = |low;
        enc = '0;
        for (int b = ple_pkg::GRP_SZ - 1; b >= 0; b--) begin
            if (low[b]) begin
                enc = ple_pkg::GRP_BW'(b);
            end
        end
    end

    assign last       = (r_grp == GW'(G - 1));
    assign o_st.done  = r_busy && (any || last);
    assign o_st.found = r_busy && any;
    assign o_index    = {r_grp, enc};

    // busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_st.done) begin
            r_busy <= 1'b0;
        end
    end

    // hit vector shifts down a group each cycle while busy
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_vec <= MW'(i_hits);
            r_grp <= '0;
        end else if (r_busy) begin
            r_vec <= r_vec >> ple_pkg::GRP_SZ;
            r_grp <= r_grp + GW'(1);
        end
    end

endmodule

@@ rtl/core/positional_list_engine.sv @@
// positional list engine: ordered list with insert, remove and find
// insert, remove and unused commands: result registered directly from the accepted request
// find: cells register hit flags, the load state starts the group-wise hit scan, result registered when it ends
// one request in flight; a new one is taken as the result register frees up
// synchronous active-low reset empties the list (count zero); entries are not cleared
`include "positional_list_engine_assert.svh"

module positional_list_engine #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ple_req_if.sink         i_req,
    ple_res_if.source       o_res
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = ple_pkg::cmp_w(DEPTH);
    localparam int SIW  = ple_pkg::scan_grp_w(DEPTH) + ple_pkg::GRP_BW;
    localparam int OCW  = ple_pkg::CNT_W;
    localparam int FIW  = ple_pkg::FIDX_W;
    localparam int VW   = ple_pkg::VAL_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0]                 r_state, n_state;
    logic [CW-1:0]              r_count, n_count;
    logic                       r_out_valid;
    logic [ple_pkg::STAT_W-1:0] r_status;
    logic [FIW-1:0]             r_fidx;
    logic [OCW-1:0]             r_ecnt;

    logic                       in_fire;
    logic                       is_ins, is_rem, is_fnd;
    logic                       full, bad_ins, bad_rem;
    logic [CMPW-1:0]            pos_x, cnt_x;
    ple_pkg::t_cell_op          op;
    logic [ple_pkg::STAT_W-1:0] imm_status;
    logic                       load_imm, load_scan;

    logic signed [VW-1:0]       entry [DEPTH];
    logic [DEPTH-1:0]           hits;
    ple_pkg::t_scan_st          scan_st;
    logic [SIW-1:0]             scan_idx;

    // handshake
    assign i_req.ready = (r_state == S_IDLE) && (!r_out_valid || o_res.ready);
    assign in_fire     = i_req.valid && i_req.ready;

    // decode and bounds checks
    always_comb begin
        is_ins  = (i_req.cmd == ple_pkg::CMD_INS);
        is_rem  = (i_req.cmd == ple_pkg::CMD_REM);
        is_fnd  = (i_req.cmd == ple_pkg::CMD_FND);
        pos_x   = CMPW'(i_req.position);
        cnt_x   = CMPW'(r_count);
        full    = (r_count == CW'(DEPTH));
        bad_ins = (pos_x > cnt_x);
        bad_rem = (pos_x >= cnt_x);
        op.ins  = in_fire && is_ins && !full && !bad_ins;
        op.rem  = in_fire && is_rem && !bad_rem;
        op.fnd  = in_fire && is_fnd;
    end

    // status of operations that finish at once
    always_comb begin
        priority if (is_ins && full) begin
            imm_status = ple_pkg::ST_FULL;
        end else if (is_ins && bad_ins) begin
            imm_status = ple_pkg::ST_BADPOS;
        end else if (is_rem && bad_rem) begin
            imm_status = ple_pkg::ST_BADPOS;
        end else begin
            imm_status = ple_pkg::ST_OK;
        end
    end

    // entry count
    always_comb begin
        priority if (op.ins) begin
            n_count = r_count + CW'(1);
        end else if (op.rem) begin
            n_count = r_count - CW'(1);
        end else begin
            n_count = r_count;
        end
    end

    // chain of cells
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic signed [VW-1:0] left, right;
        if (k == 0) begin : g_first
            assign left = i_req.item_value;
        end else begin : g_mid_l
            assign left = entry[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign right = entry[k];
        end else begin : g_mid_r
            assign right = entry[k+1];
        end
        ple_cell #(
            .IDX  (k),
            .CMPW (CMPW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (op),
            .i_pos   (pos_x),
            .i_count (cnt_x),
            .i_value (i_req.item_value),
            .i_left  (left),
            .i_right (right),
            .o_entry (entry[k]),
            .o_hit   (hits[k])
        );
    end

    // first-match scan
    ple_scan #(
        .DEPTH (DEPTH)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_LOAD),
        .i_hits  (hits),
        .o_st    (scan_st),
        .o_index (scan_idx)
    );

    // sequencer for find
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (op.fnd) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: n_state = S_SCAN;
            S_SCAN: begin
                if (scan_st.done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // result register
    assign load_imm  = in_fire && !is_fnd;
    assign load_scan = (r_state == S_SCAN) && scan_st.done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_imm || load_scan) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_imm) begin
            r_status <= imm_status;
            r_fidx   <= '0;
            r_ecnt   <= OCW'(n_count);
        end else if (load_scan) begin
            r_status <= scan_st.found ? ple_pkg::ST_OK : ple_pkg::ST_NOTFOUND;
            r_fidx   <= scan_st.found ? FIW'(scan_idx) : '0;
            r_ecnt   <= OCW'(r_count);
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_status;
    assign o_res.found_index = r_fidx;
    assign o_res.entry_count = r_ecnt;

    // checks
    `PLE_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH), "count over depth")
    `PLE_ASSERT_NEXT(a_find_loads, i_clk, i_rst_n, op.fnd, r_state == S_LOAD, "find did not start scan")
    `PLE_ASSERT_NOW(a_scan_done_state, i_clk, i_rst_n, scan_st.done, r_state == S_SCAN, "scan done outside scan")
    `PLE_ASSERT_NEXT(a_imm_result, i_clk, i_rst_n, load_imm, r_out_valid, "result not presented")

endmodule
